[design/sga_pkg.sv]
// Package with kind codes, state machine type and CORDIC constants for the gate engine.
package sga_pkg;

  typedef enum logic [3:0] {
    K_INIT = 4'd0, K_H = 4'd1, K_X = 4'd2, K_Y = 4'd3, K_Z = 4'd4,
    K_RX = 4'd5, K_RY = 4'd6, K_RZ = 4'd7, K_CX = 4'd8, K_CZ = 4'd9,
    K_READ = 4'd10
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CORDIC, S_RD_A, S_RD_B, S_MUL, S_SUM, S_WR_A, S_WR_B,
    S_RDX, S_RDX2, S_RDX3, S_DONE
  } state_t;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [17:0] HALF_SQRT_Q16 = 18'sd46341;
  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

  function automatic logic signed [33:0] atan_q30(input logic [3:0] i);
    logic signed [33:0] r;
    unique case (i)
      4'd0: r = 34'sh020000000;
      4'd1: r = 34'sh012E4051E;
      4'd2: r = 34'sh009FB385B;
      4'd3: r = 34'sh0051111D4;
      4'd4: r = 34'sh0028B0D43;
      4'd5: r = 34'sh00145D7E1;
      4'd6: r = 34'sh000A2F61E;
      4'd7: r = 34'sh000517C55;
      4'd8: r = 34'sh00028BE53;
      4'd9: r = 34'sh000145F2F;
      4'd10: r = 34'sh0000A2F98;
      4'd11: r = 34'sh0000517CC;
      4'd12: r = 34'sh000028BE6;
      4'd13: r = 34'sh0000145F3;
      4'd14: r = 34'sh00000A2FA;
      default: r = 34'sh00000517D;
    endcase
    return r;
  endfunction

endpackage

[design/statevector_gate_apply.sv]
// Top level of the state-vector gate engine: amplitude memory, CORDIC and pair update.
//
//  channel | signals                                              | direction
//  in      | in_valid, in_ready, kind, target_qubit, control_qubit, | into block
//          | angle, read_index                                      |
//  out     | out_valid, out_ready, amp_real, amp_imag, probability, | out of block
//          | status                                                 |
//  cfg     | cfg_we, cfg_data (qubit_count)                          | into block
//
// A gate runs the CORDIC steps (every gate; only rotations use the result), then
// S_RD_A to S_WR_B for each of its 2^(n-1) pairs; a pair whose control bit is clear
// passes S_RD_A alone, and a last S_RD_A closes. A bad qubit ends in S_CORDIC. Init
// sweeps 2^n entries, a read passes S_RDX to S_RDX3, and S_DONE posts the result.
// After reset all 2^MAX_QUBITS entries are cleared before the first item is taken.
// One item is in work at a time; the result register holds a beat until out_ready.
module statevector_gate_apply #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_BITS = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  kind,
  input  logic [3:0]  target_qubit,
  input  logic [3:0]  control_qubit,
  input  logic signed [15:0] angle,
  input  logic [9:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [17:0] amp_real,
  output logic signed [17:0] amp_imag,
  output logic [16:0] probability,
  output logic        status,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data
);
  import sga_pkg::*;

  localparam int AW = MAX_QUBITS;
  localparam int DEPTH = 1 << MAX_QUBITS;
  localparam int FRAC = AMP_BITS - 2;
  localparam int PW = AMP_BITS + 18;
  localparam int SW = PW + 3;
  localparam int MW = 2 * AMP_BITS + 1;
  localparam logic signed [AMP_BITS-1:0] AMP_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
  localparam logic signed [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};

  // Each entry holds the real part above the imaginary part.
  logic [2*AMP_BITS-1:0] mem [DEPTH];
  logic [2*AMP_BITS-1:0] rd_data;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [2*AMP_BITS-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  state_t state, state_next;
  logic [3:0] qcount;
  logic [4:0] nq;
  logic [AW:0] cnt;
  kind_t k;
  logic [3:0] tq, cq;
  logic [15:0] ang_r;
  logic [AW-1:0] ridx;
  logic signed [33:0] cx, cy, cz;
  logic flip;
  logic [3:0] cstep;
  logic signed [17:0] m [8];
  logic signed [AMP_BITS-1:0] ar, ai, br, bi;
  logic signed [PW-1:0] pr [16];
  logic signed [AMP_BITS-1:0] nr0, ni0, nr1, ni1;
  logic [AW-1:0] ia, ib;
  logic [AW-1:0] tmask, cmask;
  logic [AW:0] dim;
  logic bad, two;

  // Init sweeps only 2^n entries; the reset sweep covers the whole memory.
  logic clear_all;
  logic [AW:0] clear_last;

  always_ff @(posedge clk) begin
    if (rst) qcount <= 4'd1;
    else if (cfg_we) qcount <= cfg_data;
  end

  always_comb begin
    if (qcount < 4'd1) nq = 5'd1;
    else if ({1'b0, qcount} > 5'(MAX_QUBITS)) nq = 5'(MAX_QUBITS);
    else nq = {1'b0, qcount};
  end
  assign dim = (AW+1)'(1) << nq;
  assign clear_last = clear_all ? (AW+1)'(DEPTH - 1) : dim - 1'b1;

  assign two = (k == K_CX) || (k == K_CZ);
  assign bad = ({1'b0, tq} >= nq) || (two && (({1'b0, cq} >= nq) || cq == tq));
  assign tmask = AW'(1) << tq;
  assign cmask = two ? (AW'(1) << cq) : '0;

  // Pair index: insert a zero at the target bit of the running count.
  logic [AW-1:0] cnt_lo, low_mask;
  assign cnt_lo = cnt[AW-1:0];
  assign low_mask = tmask - AW'(1);
  assign ia = ((cnt_lo & ~low_mask) << 1) | (cnt_lo & low_mask);
  assign ib = ia | tmask;

  logic res_pending;
  logic signed [17:0] res_re, res_im;
  logic [16:0] res_p;
  logic res_st;
  logic res_move;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready && res_pending);
  assign res_move = res_pending && (!out_valid || out_ready);

  // CORDIC step on the half angle.
  logic signed [33:0] cx_sh, cy_sh;
  assign cx_sh = cx >>> cstep;
  assign cy_sh = cy >>> cstep;

  function automatic logic signed [17:0] rnd30(input logic signed [33:0] v, input logic neg);
    logic signed [33:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536) r = 34'sd65536;
    if (r < -34'sd65536) r = -34'sd65536;
    return neg ? -18'(r) : 18'(r);
  endfunction

  function automatic logic signed [AMP_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + SW'(32768)) >>> 16;
    if (r > SW'(AMP_MAX)) return AMP_MAX;
    if (r < SW'(AMP_MIN)) return AMP_MIN;
    return r[AMP_BITS-1:0];
  endfunction

  logic signed [SW-1:0] sr0, si0, sr1, si1;
  logic signed [MW-1:0] mag;
  logic [MW-1:0] pr_sh;

  always_comb begin
    logic signed [AMP_BITS-1:0] re_v, im_v;
    re_v = rd_data[2*AMP_BITS-1:AMP_BITS];
    im_v = rd_data[AMP_BITS-1:0];
    mag = MW'(re_v) * MW'(re_v) + MW'(im_v) * MW'(im_v);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        if (kind == K_INIT) state_next = S_CLEAR;
        else if (kind == K_READ) state_next = S_RDX;
        else if (kind >= K_H && kind <= K_CZ) state_next = S_CORDIC;
        else state_next = S_DONE;
      end
      S_CLEAR:  if (cnt == clear_last) state_next = clear_all ? S_IDLE : S_DONE;
      S_CORDIC: begin
        if (bad) state_next = S_DONE;
        else if (cstep == 4'(CORDIC_STEPS - 1)) state_next = S_RD_A;
      end
      S_RD_A: begin
        if (cnt == dim >> 1) state_next = S_DONE;
        else if ((ia & cmask) != cmask) state_next = S_RD_A;
        else state_next = S_RD_B;
      end
      S_RD_B:   state_next = S_MUL;
      S_MUL:    state_next = S_SUM;
      S_SUM:    state_next = S_WR_A;
      S_WR_A:   state_next = S_WR_B;
      S_WR_B:   state_next = S_RD_A;
      S_RDX:    state_next = S_RDX2;
      S_RDX2:   state_next = S_RDX3;
      S_RDX3:   state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      out_valid <= 1'b0;
      res_pending <= 1'b0;
    end else begin
      if (state == S_DONE) res_pending <= 1'b1;
      else if (res_move) res_pending <= 1'b0;
      if (res_move) begin
        out_valid <= 1'b1;
        amp_real <= res_re;
        amp_imag <= res_im;
        probability <= res_p;
        status <= res_st;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      state <= state_next;
      unique case (state)
        S_CLEAR: cnt <= cnt + 1'b1;
        S_IDLE: if (in_valid && in_ready) begin
          k <= kind_t'(kind);
          tq <= target_qubit; cq <= control_qubit;
          ang_r <= angle; ridx <= AW'(read_index);
          cnt <= '0;
          res_re <= '0; res_im <= '0; res_p <= '0; res_st <= 1'b0;
          cstep <= '0;
          begin
            logic [31:0] p;
            p = {angle, 16'd0};
            flip <= (p - 32'h40000000) < 32'h80000000;
            if ((p - 32'h40000000) < 32'h80000000) p = p + 32'h80000000;
            cz <= 34'(signed'(p));
          end
          cx <= CORDIC_GAIN_Q30; cy <= '0;
        end
        S_CORDIC: begin
          if (bad) begin
            res_st <= 1'b1;
          end else begin
            if (cz >= 0) begin
              cx <= cx - cy_sh; cy <= cy + cx_sh; cz <= cz - atan_q30(cstep);
            end else begin
              cx <= cx + cy_sh; cy <= cy - cx_sh; cz <= cz + atan_q30(cstep);
            end
            cstep <= cstep + 1'b1;
          end
        end
        S_RD_A: begin
          if (cnt != dim >> 1 && (ia & cmask) != cmask) cnt <= cnt + 1'b1;
          if (cnt == '0) begin
            logic signed [17:0] c, s;
            logic signed [17:0] mm [8];
            c = rnd30(cx, flip); s = rnd30(cy, flip);
            for (int i = 0; i < 8; i++) mm[i] = '0;
            case (k)
              K_H: begin
                mm[0] = HALF_SQRT_Q16; mm[2] = HALF_SQRT_Q16;
                mm[4] = HALF_SQRT_Q16; mm[6] = -HALF_SQRT_Q16;
              end
              K_X, K_CX: begin mm[2] = ONE_Q16; mm[4] = ONE_Q16; end
              K_Y: begin mm[3] = -ONE_Q16; mm[5] = ONE_Q16; end
              K_Z, K_CZ: begin mm[0] = ONE_Q16; mm[6] = -ONE_Q16; end
              K_RX: begin mm[0] = c; mm[3] = -s; mm[5] = -s; mm[6] = c; end
              K_RY: begin mm[0] = c; mm[2] = -s; mm[4] = s; mm[6] = c; end
              default: begin mm[0] = c; mm[1] = -s; mm[6] = c; mm[7] = s; end
            endcase
            for (int i = 0; i < 8; i++) m[i] <= mm[i];
          end
        end
        S_RD_B: begin
          ar <= rd_data[2*AMP_BITS-1:AMP_BITS]; ai <= rd_data[AMP_BITS-1:0];
        end
        S_MUL: begin
          br <= rd_data[2*AMP_BITS-1:AMP_BITS]; bi <= rd_data[AMP_BITS-1:0];
        end
        S_SUM: begin
          for (int r = 0; r < 2; r++) begin
            pr[8*r+0] <= PW'(m[4*r+0]) * PW'(ar); pr[8*r+1] <= PW'(m[4*r+1]) * PW'(ai);
            pr[8*r+2] <= PW'(m[4*r+2]) * PW'(br); pr[8*r+3] <= PW'(m[4*r+3]) * PW'(bi);
            pr[8*r+4] <= PW'(m[4*r+0]) * PW'(ai); pr[8*r+5] <= PW'(m[4*r+1]) * PW'(ar);
            pr[8*r+6] <= PW'(m[4*r+2]) * PW'(bi); pr[8*r+7] <= PW'(m[4*r+3]) * PW'(br);
          end
        end
        S_WR_A: begin
          nr1 <= sat(sr1); ni1 <= sat(si1);
        end
        S_WR_B: cnt <= cnt + 1'b1;
        S_RDX3: begin
          res_re <= 18'(signed'(rd_data[2*AMP_BITS-1:AMP_BITS]));
          res_im <= 18'(signed'(rd_data[AMP_BITS-1:0]));
          res_p <= (pr_sh > MW'(65536)) ? 17'd65536 : pr_sh[16:0];
        end
        default: ;
      endcase
    end
  end

  assign sr0 = SW'(pr[0]) - SW'(pr[1]) + SW'(pr[2]) - SW'(pr[3]);
  assign si0 = SW'(pr[4]) + SW'(pr[5]) + SW'(pr[6]) + SW'(pr[7]);
  assign sr1 = SW'(pr[8]) - SW'(pr[9]) + SW'(pr[10]) - SW'(pr[11]);
  assign si1 = SW'(pr[12]) + SW'(pr[13]) + SW'(pr[14]) + SW'(pr[15]);
  assign nr0 = sat(sr0);
  assign ni0 = sat(si0);

  localparam int PSH = 2 * FRAC - 16;
  assign pr_sh = (PSH > 0) ? ((mag + (MW'(1) << (PSH > 0 ? PSH - 1 : 0))) >> PSH)
                           : (mag << (PSH < 0 ? -PSH : 0));

  always_comb begin
    we = 1'b0; waddr = ia; raddr = ia; wdata = {nr0, ni0};
    unique case (state)
      S_CLEAR: begin
        we = 1'b1; waddr = cnt[AW-1:0];
        wdata = (cnt == '0) ? {AMP_BITS'(1 << FRAC), {AMP_BITS{1'b0}}} : '0;
      end
      S_RD_A: raddr = ia;
      S_RD_B: raddr = ib;
      S_WR_A: begin we = 1'b1; waddr = ia; wdata = {nr0, ni0}; end
      S_WR_B: begin we = 1'b1; waddr = ib; wdata = {nr1, ni1}; end
      S_RDX: raddr = ridx & AW'(dim - 1'b1);
      // Hold the address so the read data stays put while it is captured.
      S_RDX2: raddr = ridx & AW'(dim - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) clear_all <= 1'b1;
    else if (state == S_IDLE) clear_all <= 1'b0;
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid);
  assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_CLEAR || state == S_WR_A || state == S_WR_B))
    else $error("write outside clear or write-back");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready) else $error("item taken during clear");
endmodule

[test/statevector_gate_apply_tb.sv]
// Testbench for the state-vector gate engine, checked against a local predictor.
module statevector_gate_apply_tb;
  import sga_pkg::*;

  typedef struct {
    logic signed [17:0] re;
    logic signed [17:0] im;
    logic [16:0]        prob;
    logic               stat;
  } amp_beat_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_we = 0;
  logic [3:0] kind = 0, target_qubit = 0, control_qubit = 0, cfg_data = 0;
  logic signed [15:0] angle = 0;
  logic [9:0] read_index = 0;
  logic in_ready, out_valid, status;
  logic signed [17:0] amp_real, amp_imag;
  logic [16:0] probability;

  statevector_gate_apply dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .target_qubit(target_qubit), .control_qubit(control_qubit), .angle(angle),
    .read_index(read_index), .out_valid(out_valid), .out_ready(out_ready),
    .amp_real(amp_real), .amp_imag(amp_imag), .probability(probability),
    .status(status), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Model of the vector and the qubit count register.
  longint sv_re[1024], sv_im[1024];
  logic [3:0] qubits_reg;
  amp_beat_t pending_amps[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;

  longint arctan_q30[16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D};

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("statevector_gate_apply_tb: errors");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);

  function automatic longint sat18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint q30_to_q16(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  task automatic half_angle_cos_sin(input logic [15:0] a, output longint c, output longint s);
    logic [31:0] p;
    bit flip;
    longint x, y, z, xn;
    p = {a, 16'h0};
    flip = (p - 32'h40000000) < 32'h80000000;
    if (flip) p = p + 32'h80000000;
    z = longint'($signed(p));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i); y = y + (x >>> i); z = z - arctan_q30[i];
      end else begin
        xn = x + (y >>> i); y = y - (x >>> i); z = z + arctan_q30[i];
      end
      x = xn;
    end
    c = q30_to_q16(x);
    s = q30_to_q16(y);
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  task automatic clear_vector(input int dim);
    for (int i = 0; i < dim; i++) begin
      sv_re[i] = 0; sv_im[i] = 0;
    end
    sv_re[0] = 65536;
  endtask

  // Works out the state update and the result beat for one accepted item.
  task automatic predict_amp_beat(input logic [3:0] k, input logic [3:0] tq,
                                  input logic [3:0] cq, input logic [15:0] ang,
                                  input logic [9:0] ridx);
    amp_beat_t b;
    int n, dim, j, idx;
    bit two;
    longint m[8], c, s, ar, ai, br, bi, r0, i0, r1, i1, mag, pr;
    int tmask, cmask;
    b = '{0, 0, 0, 0};
    n = (qubits_reg < 1) ? 1 : (qubits_reg > 10) ? 10 : qubits_reg;
    dim = 1 << n;
    m = '{0, 0, 0, 0, 0, 0, 0, 0};
    two = (k == K_CX) || (k == K_CZ);
    if (k == K_INIT) begin
      clear_vector(dim);
    end else if (k == K_READ) begin
      idx = ridx & (dim - 1);
      mag = sv_re[idx] * sv_re[idx] + sv_im[idx] * sv_im[idx];
      pr = (mag + 32768) >> 16;
      b.prob = (pr > 65536) ? 17'd65536 : pr[16:0];
      b.re = sv_re[idx][17:0];
      b.im = sv_im[idx][17:0];
    end else if (k >= K_H && k <= K_CZ) begin
      if (tq >= n || (two && (cq >= n || cq == tq))) begin
        b.stat = 1;
      end else begin
        tmask = 1 << tq;
        cmask = two ? (1 << cq) : 0;
        case (k)
          K_H: begin
            m[0] = 46341; m[2] = 46341; m[4] = 46341; m[6] = -46341;
          end
          K_X, K_CX: begin
            m[2] = 65536; m[4] = 65536;
          end
          K_Y: begin
            m[3] = -65536; m[5] = 65536;
          end
          K_Z, K_CZ: begin
            m[0] = 65536; m[6] = -65536;
          end
          K_RX: begin
            half_angle_cos_sin(ang, c, s);
            m[0] = c; m[3] = -s; m[5] = -s; m[6] = c;
          end
          K_RY: begin
            half_angle_cos_sin(ang, c, s);
            m[0] = c; m[2] = -s; m[4] = s; m[6] = c;
          end
          default: begin
            half_angle_cos_sin(ang, c, s);
            m[0] = c; m[1] = -s; m[6] = c; m[7] = s;
          end
        endcase
        for (int i = 0; i < dim; i++) begin
          if ((i & tmask) == 0 && (i & cmask) == cmask) begin
            j = i | tmask;
            ar = sv_re[i]; ai = sv_im[i]; br = sv_re[j]; bi = sv_im[j];
            r0 = m[0] * ar - m[1] * ai + m[2] * br - m[3] * bi;
            i0 = m[0] * ai + m[1] * ar + m[2] * bi + m[3] * br;
            r1 = m[4] * ar - m[5] * ai + m[6] * br - m[7] * bi;
            i1 = m[4] * ai + m[5] * ar + m[6] * bi + m[7] * br;
            sv_re[i] = sat18((r0 + 32768) >>> 16);
            sv_im[i] = sat18((i0 + 32768) >>> 16);
            sv_re[j] = sat18((r1 + 32768) >>> 16);
            sv_im[j] = sat18((i1 + 32768) >>> 16);
          end
        end
      end
    end
    pending_amps.insert(pending_amps.size(), b);
  endtask

  always @(posedge clk) begin
    amp_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_amps.size() == 0) begin
        $display("%0t: result beat with nothing pending: re %0d im %0d prob %0d status %0d",
                 $time, amp_real, amp_imag, probability, status);
        errors++;
      end else begin
        e = pending_amps.pop_front();
        if (amp_real !== e.re || amp_imag !== e.im || probability !== e.prob ||
            status !== e.stat) begin
          $display("%0t: expected re %0d im %0d prob %0d status %0d, got %0d %0d %0d %0d",
                   $time, e.re, e.im, e.prob, e.stat, amp_real, amp_imag, probability, status);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [3:0] k, input logic [3:0] tq, input logic [3:0] cq,
                           input logic [15:0] ang, input logic [9:0] ridx);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k; target_qubit <= tq; control_qubit <= cq; angle <= ang; read_index <= ridx;
    predict_amp_beat(k, tq, cq, ang, ridx);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    if (in_valid) begin
      in_valid <= 0;
      @(posedge clk);
    end
    while (pending_amps.size() != 0) @(posedge clk);
  endtask

  task automatic set_qubits(input logic [3:0] v);
    wait_drained();
    repeat (10) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    qubits_reg = v;
  endtask

  // A random item; well-formed gates and reads dominate, the rest is noise.
  task automatic random_item(input int n);
    int r;
    logic [3:0] k, tq, cq;
    r = $urandom_range(99);
    tq = 4'($urandom_range(n - 1));
    cq = 4'($urandom_range(n - 1));
    if (r < 4) k = K_INIT;
    else if (r < 30) k = K_READ;
    else if (r < 90) k = 4'($urandom_range(9, 1));
    else begin
      k = 4'($urandom_range(15));
      tq = 4'($urandom_range(15));
      cq = 4'($urandom_range(15));
    end
    send_item(k, tq, cq, 16'($urandom), 10'($urandom));
  endtask

  task automatic test_single_qubit_gates();
    set_qubits(1);
    send_item(K_READ, 0, 0, 0, 10'h3FF);
    send_item(K_H, 0, 0, 0, 0);
    send_item(K_READ, 0, 0, 0, 1);
    send_item(K_X, 0, 0, 0, 0);
    send_item(K_Y, 0, 0, 0, 0);
    send_item(K_Z, 0, 0, 0, 0);
    send_item(K_READ, 0, 0, 0, 0);
    send_item(K_RX, 0, 0, 16'h7FFF, 0);
    send_item(K_RY, 0, 0, 16'h8000, 0);
    send_item(K_RZ, 0, 0, 16'h4000, 0);
    send_item(K_RY, 0, 0, 16'h2000, 0);
    send_item(K_READ, 0, 0, 0, 1);
    send_item(K_H, 4'hF, 0, 0, 0);
    send_item(4'd11, 0, 0, 0, 0);
    send_item(4'd15, 4'hF, 4'hF, 16'hFFFF, 10'h3FF);
    send_item(K_INIT, 0, 0, 0, 0);
  endtask

  task automatic test_two_qubit_gates();
    set_qubits(2);
    send_item(K_H, 1, 0, 0, 0);
    send_item(K_CX, 0, 1, 0, 0);
    send_item(K_CZ, 1, 0, 0, 0);
    send_item(K_CX, 1, 1, 0, 0);
    send_item(K_CZ, 0, 2, 0, 0);
    send_item(K_READ, 0, 0, 0, 3);
    send_item(K_READ, 0, 0, 0, 0);
    send_item(K_INIT, 0, 0, 0, 0);
  endtask

  task automatic test_qubit_count_extremes();
    // A count of zero acts as one qubit and a count above ten as ten.
    set_qubits(0);
    send_item(K_H, 1, 0, 0, 0);
    send_item(K_RX, 0, 0, 16'h1234, 0);
    set_qubits(10);
    send_item(K_INIT, 0, 0, 0, 0);
    send_item(K_H, 9, 0, 0, 0);
    send_item(K_CX, 0, 9, 0, 0);
    send_item(K_READ, 0, 0, 0, 10'h201);
    set_qubits(15);
    send_item(K_RZ, 9, 0, 16'hC000, 0);
    send_item(K_READ, 0, 0, 0, 10'h3FF);
  endtask

  task automatic test_random_sequences();
    int n;
    for (int ph = 0; ph < 11; ph++) begin
      n = (ph == 5) ? 10 : $urandom_range(5, 1);
      set_qubits(4'(n));
      quiet = (ph == 3);
      if (ph == 7) wait_drained();
      for (int i = 0; i < ((n == 10) ? 8 : 54); i++) begin
        if (i == 25 && ph == 2) wait_drained();
        random_item(n);
      end
    end
    quiet = 0;
  endtask

  initial begin
    qubits_reg = 1;
    clear_vector(1024);
    repeat (8) @(posedge clk);
    rst <= 0;
    test_single_qubit_gates();
    test_two_qubit_gates();
    test_qubit_count_extremes();
    test_random_sequences();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("statevector_gate_apply_tb: clean");
    else
      $display("statevector_gate_apply_tb: errors");
    $finish;
  end
endmodule
